// ===== design/irup_pkg.sv =====
// Shared types, status codes and keyword table for the ident reply username parser.
`default_nettype none
package irup_pkg;

	localparam int MAX_USER_LEN_DEF = 10;
	localparam int MAX_MSG_LEN_DEF  = 511;
	localparam int KW_LEN           = 6;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_NO_COMMA = 3'd1,
		ST_NO_PCOL  = 3'd2,
		ST_NO_USRID = 3'd3,
		ST_NO_COLON = 3'd4,
		ST_NO_OSCOL = 3'd5,
		ST_EMPTY    = 3'd6
	} status_t;

	typedef struct packed {
		logic [7:0] reply_byte;
		logic       end_of_reply;
	} reply_item_t;

	typedef struct packed {
		logic [7:0] user_byte;
		logic       byte_valid;
		logic       done_res;
		status_t    status;
	} user_item_t;

	function automatic logic [7:0] kw_char(input logic [2:0] idx);
		logic [7:0] c;
		unique case (idx)
			3'd0: c = 8'h55; // U
			3'd1: c = 8'h53; // S
			3'd2: c = 8'h45; // E
			3'd3: c = 8'h52; // R
			3'd4: c = 8'h49; // I
			3'd5: c = 8'h44; // D
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return (b == 8'd32) || (b == 8'd9);
	endfunction

	// signed-char view: 128..255 count as control/blank
	function automatic logic is_low(input logic [7:0] b);
		return (b <= 8'd32) || b[7];
	endfunction

endpackage
`default_nettype wire

// ===== design/irup_stream_if.sv =====
// Valid/ready stream interface with a typed payload.
`default_nettype none
interface irup_stream_if #(
	parameter type T = logic
);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== design/ident_reply_username_parser.sv =====
// Top level: ident reply username parser with registered result channel.
//
// Channels: reply (sink) carries one reply byte per transfer with
// end_of_reply on the final byte; user (source) carries result items.
// A result is produced when a username byte is passed on or when the
// transfer carries end_of_reply; other bytes produce no result.
// A result is presented on user in the cycle after its byte's
// transfer. Throughput: one byte per cycle while user accepts
// results, set by the single result register; reply.ready stays
// high while that register is empty or being drained in the same cycle.
// Stall: when user.ready is low and a result is held, reply.ready drops
// and the held result stays until taken.
// Reset (arst_n low): parser returns to waiting for the first comma,
// counters clear and the result register empties. After end_of_reply
// the parser restarts the same way for the next reply.
// Username is cut to MAX_USER_LEN bytes; bytes past MAX_MSG_LEN or after
// a zero byte are ignored until end_of_reply.
`default_nettype none
module ident_reply_username_parser #(
	parameter int MAX_USER_LEN = irup_pkg::MAX_USER_LEN_DEF,
	parameter int MAX_MSG_LEN  = irup_pkg::MAX_MSG_LEN_DEF
) (
	input wire               clk,
	input wire               arst_n,
	irup_stream_if.sink      reply,
	irup_stream_if.source    user
);
	logic                 step;
	logic                 res_valid;
	irup_pkg::user_item_t res;
	logic                 out_valid_q;
	irup_pkg::user_item_t out_data_q;

	assign reply.ready = !out_valid_q || user.ready;
	assign step        = reply.valid && reply.ready;

	irup_parse #(
		.MAX_USER_LEN (MAX_USER_LEN),
		.MAX_MSG_LEN  (MAX_MSG_LEN)
	) u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (reply.data),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && res_valid) begin
			out_valid_q <= 1'b1;
		end else if (user.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && res_valid) begin
			out_data_q <= res;
		end
	end

	assign user.valid = out_valid_q;
	assign user.data  = out_data_q;

endmodule
`default_nettype wire

// ===== design/irup_parse.sv =====
// Reply grammar state machine: phase, keyword match, counters and result item.
`default_nettype none
module irup_parse #(
	parameter int MAX_USER_LEN = irup_pkg::MAX_USER_LEN_DEF,
	parameter int MAX_MSG_LEN  = irup_pkg::MAX_MSG_LEN_DEF
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  step,
	input  irup_pkg::reply_item_t item,
	output logic                 res_valid,
	output irup_pkg::user_item_t res
);
	localparam int CW = $clog2(MAX_MSG_LEN + 1);
	localparam int UW = $clog2(MAX_USER_LEN + 1);

	typedef enum logic [3:0] {
		PH_COMMA   = 4'd0,
		PH_PCOLON  = 4'd1,
		PH_KEYWORD = 4'd2,
		PH_KWCOLON = 4'd3,
		PH_OS      = 4'd4,
		PH_PREUSER = 4'd5,
		PH_USER    = 4'd6,
		PH_HALT    = 4'd8
	} phase_t;

	phase_t             phase_q, phase_n;
	logic [2:0]         kw_q, kw_n;
	logic [CW-1:0]      cnt_q, cnt_n;
	logic [UW-1:0]      ulen_q, ulen_n;
	irup_pkg::status_t  fail_q, fail_n;
	logic               emit;
	logic [7:0]         b;

	function automatic irup_pkg::status_t phase_status(input phase_t ph,
		input irup_pkg::status_t f);
		irup_pkg::status_t s;
		unique case (ph)
			PH_COMMA:   s = irup_pkg::ST_NO_COMMA;
			PH_PCOLON:  s = irup_pkg::ST_NO_PCOL;
			PH_KEYWORD: s = irup_pkg::ST_NO_USRID;
			PH_KWCOLON: s = irup_pkg::ST_NO_COLON;
			PH_OS:      s = irup_pkg::ST_NO_OSCOL;
			PH_PREUSER: s = irup_pkg::ST_EMPTY;
			PH_USER:    s = irup_pkg::ST_OK;
			default:    s = f;
		endcase
		return s;
	endfunction

	assign b = item.reply_byte;

	always_comb begin
		phase_n = phase_q;
		kw_n    = kw_q;
		cnt_n   = cnt_q;
		ulen_n  = ulen_q;
		fail_n  = fail_q;
		emit    = 1'b0;
		if (phase_q == PH_HALT) begin
		end else if (cnt_q >= CW'(MAX_MSG_LEN) || b == 8'd0) begin
			fail_n  = phase_status(phase_q, fail_q);
			phase_n = PH_HALT;
		end else begin
			cnt_n = cnt_q + CW'(1);
			unique case (phase_q)
				PH_COMMA: begin
					if (b == 8'h2C) phase_n = PH_PCOLON;
				end
				PH_PCOLON: begin
					if (b == 8'h3A) begin
						phase_n = PH_KEYWORD;
						kw_n    = 3'd0;
					end
				end
				PH_KEYWORD: begin
					if (kw_q == 3'd0 && irup_pkg::is_blank(b)) begin
					end else if (kw_q < 3'(irup_pkg::KW_LEN) && b == irup_pkg::kw_char(kw_q)) begin
						if (kw_q == 3'(irup_pkg::KW_LEN - 1)) begin
							kw_n    = 3'd0;
							phase_n = PH_KWCOLON;
						end else begin
							kw_n = kw_q + 3'd1;
						end
					end else begin
						fail_n  = irup_pkg::ST_NO_USRID;
						phase_n = PH_HALT;
					end
				end
				PH_KWCOLON: begin
					if (irup_pkg::is_blank(b)) begin
					end else if (b == 8'h3A) begin
						phase_n = PH_OS;
					end else begin
						fail_n  = irup_pkg::ST_NO_COLON;
						phase_n = PH_HALT;
					end
				end
				PH_OS: begin
					if (b == 8'h3A) phase_n = PH_PREUSER;
				end
				PH_PREUSER: begin
					if (b == 8'h7E || b == 8'h5E || irup_pkg::is_low(b)) begin
					end else if (b == 8'h40 || b == 8'h3A) begin
						fail_n  = irup_pkg::ST_EMPTY;
						phase_n = PH_HALT;
					end else begin
						emit    = 1'b1;
						ulen_n  = UW'(1);
						phase_n = PH_USER;
					end
				end
				PH_USER: begin
					if (irup_pkg::is_low(b) || b == 8'h40 || b == 8'h3A) begin
						fail_n  = irup_pkg::ST_OK;
						phase_n = PH_HALT;
					end else if (ulen_q < UW'(MAX_USER_LEN)) begin
						emit   = 1'b1;
						ulen_n = ulen_q + UW'(1);
					end
				end
				default: begin
				end
			endcase
		end

		res_valid      = emit || item.end_of_reply;
		res.user_byte  = emit ? b : 8'd0;
		res.byte_valid = emit;
		res.done_res   = item.end_of_reply;
		res.status     = item.end_of_reply ? phase_status(phase_n, fail_n) : irup_pkg::ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_COMMA;
			kw_q    <= 3'd0;
			cnt_q   <= '0;
			ulen_q  <= '0;
			fail_q  <= irup_pkg::ST_OK;
		end else if (step) begin
			if (item.end_of_reply) begin
				phase_q <= PH_COMMA;
				kw_q    <= 3'd0;
				cnt_q   <= '0;
				ulen_q  <= '0;
				fail_q  <= irup_pkg::ST_OK;
			end else begin
				phase_q <= phase_n;
				kw_q    <= kw_n;
				cnt_q   <= cnt_n;
				ulen_q  <= ulen_n;
				fail_q  <= fail_n;
			end
		end
	end

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		step && item.end_of_reply |=> phase_q == PH_COMMA && cnt_q == '0)
		else $error("reply end did not restart parser");
	a_emit_ok: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.byte_valid |-> res.status == irup_pkg::ST_OK)
		else $error("username byte with failing status");
	a_ulen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ulen_q <= UW'(MAX_USER_LEN))
		else $error("username length over limit");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_MSG_LEN))
		else $error("byte count over limit");
	a_emit_phase: assert property (@(posedge clk) disable iff (!arst_n)
		step && emit && !item.end_of_reply |=> phase_q == PH_USER && ulen_q != '0)
		else $error("emit outside username phase");

endmodule
`default_nettype wire
